>>> design/unicode_script_range_lookup_macros.svh
// Assertion macros shared by the checker of the script lookup block.
// Depends on nothing; each macro expects clk in scope, and all but USRL_ASSERT_RST also rst_n.
`ifndef UNICODE_SCRIPT_RANGE_LOOKUP_MACROS_SVH
`define UNICODE_SCRIPT_RANGE_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define USRL_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define USRL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define USRL_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/usrl_pkg.sv
// Shared types, constants and table sizes of the script lookup block.
// Depends on nothing; the front, back, top-level and checker files use it by scoped names.
`default_nettype none
package usrl_pkg;

  // Table depths and set limits.
  localparam int SCRIPT_RANGES = 2048;
  localparam int EXT_RANGES    = 512;
  localparam int SET_RECORDS   = 256;
  localparam int POOL_ENTRIES  = 1024;
  localparam int MAX_SET_SIZE  = 32;
  localparam int RESULT_LIMIT  = 32;

  localparam int SR_AW   = $clog2(SCRIPT_RANGES);
  localparam int ER_AW   = $clog2(EXT_RANGES);
  localparam int SET_AW  = $clog2(SET_RECORDS);
  localparam int POOL_AW = $clog2(POOL_ENTRIES);
  localparam int SETN_W  = $clog2(SET_RECORDS) + 1;
  localparam int POOLN_W = $clog2(POOL_ENTRIES) + 1;
  // Search index and count width, wide enough to hold either table depth.
  localparam int SRCH_W  = ((SR_AW > ER_AW) ? SR_AW : ER_AW) + 1;

  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  localparam logic [20:0] CP_LIMIT = 21'h10FFFF;

  // Command codes.
  localparam logic [2:0] CMD_LOOKUP = 3'd0;
  localparam logic [2:0] CMD_SCRIPT = 3'd1;
  localparam logic [2:0] CMD_EXT    = 3'd2;
  localparam logic [2:0] CMD_SET    = 3'd3;
  localparam logic [2:0] CMD_POOL   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SCRIPT_COUNT = 3'd0;
  localparam logic [2:0] CFG_EXT_COUNT    = 3'd1;
  localparam logic [2:0] CFG_SET_COUNT    = 3'd2;
  localparam logic [2:0] CFG_POOL_COUNT   = 3'd3;
  localparam logic [2:0] CFG_UNKNOWN_ID   = 3'd4;
  localparam logic [2:0] CFG_COMMON_ID    = 3'd5;
  localparam logic [2:0] CFG_INHERITED_ID = 3'd6;

  typedef enum logic [2:0] {
    OP_LOOKUP, OP_SCRIPT, OP_EXT, OP_SET, OP_POOL, OP_NOP
  } op_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [20:0] codepoint;
    logic [10:0] entry_index;
    logic [20:0] first_codepoint;
    logic [20:0] last_codepoint;
    logic [7:0]  script_value;
    logic [7:0]  set_number;
    logic [9:0]  pool_offset;
    logic [5:0]  member_count;
  } in_word_t;

  typedef struct packed {
    logic [7:0] primary_script;
    logic       primary_neutral;
    logic       has_extensions;
    logic [7:0] member_script;
    logic [4:0] member_position;
    logic       member_valid;
    logic       last;
  } out_word_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    op_t      op;
    logic     oor;
    in_word_t word;
  } qitem_t;

  typedef struct packed {
    logic [11:0] script_range_count;
    logic [9:0]  ext_range_count;
    logic [8:0]  set_record_count;
    logic [10:0] pool_count;
    logic [7:0]  unknown_script_id;
    logic [7:0]  common_script_id;
    logic [7:0]  inherited_script_id;
  } cfg_t;

  typedef struct packed {
    logic [20:0] lo;
    logic [20:0] hi;
    logic [7:0]  tag;
  } range_t;

  typedef struct packed {
    logic [9:0] offset;
    logic [5:0] count;
  } set_rec_t;

endpackage
`default_nettype wire

>>> design/usrl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none
module usrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/usrl_front.sv
// Front end: accepts input words, classifies them and queues them.
// Depends on usrl_pkg.
`default_nettype none
module usrl_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire usrl_pkg::in_word_t in_word,
  output logic                   in_full,
  output logic                   q_valid,
  output usrl_pkg::qitem_t       q_item,
  input  wire logic              q_pop
);

  usrl_pkg::qitem_t          slot_r [usrl_pkg::Q_DEPTH];
  logic [usrl_pkg::Q_PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [usrl_pkg::Q_PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [usrl_pkg::Q_PW:0]   cnt_r, cnt_nxt;
  usrl_pkg::qitem_t          cls;
  logic                      do_push, do_pop;

  // Decode the command into an operation.
  always_comb begin
    cls.word = in_word;
    cls.oor  = (in_word.codepoint > usrl_pkg::CP_LIMIT);
    unique case (in_word.command)
      usrl_pkg::CMD_LOOKUP: cls.op = usrl_pkg::OP_LOOKUP;
      usrl_pkg::CMD_SCRIPT: cls.op = usrl_pkg::OP_SCRIPT;
      usrl_pkg::CMD_EXT:    cls.op = usrl_pkg::OP_EXT;
      usrl_pkg::CMD_SET:    cls.op = usrl_pkg::OP_SET;
      usrl_pkg::CMD_POOL:   cls.op = usrl_pkg::OP_POOL;
      default:              cls.op = usrl_pkg::OP_NOP;
    endcase
  end

  assign in_full = (cnt_r == (usrl_pkg::Q_PW+1)'(usrl_pkg::Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = slot_r[rd_ptr_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && q_valid;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == usrl_pkg::Q_PW'(usrl_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == usrl_pkg::Q_PW'(usrl_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + (usrl_pkg::Q_PW+1)'(do_push) - (usrl_pkg::Q_PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

>>> design/usrl_back.sv
// Back end: performs table loads, both binary searches and member output.
// Depends on usrl_pkg and usrl_ram.
`default_nettype none
module usrl_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire usrl_pkg::cfg_t     cfg,
  input  wire logic               q_valid,
  input  wire usrl_pkg::qitem_t   q_item,
  output logic                    q_pop,
  output logic                    out_empty,
  output usrl_pkg::out_word_t     out_word,
  input  wire logic               out_pop
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ACK, ST_SRCH, ST_SWAIT, ST_CHK, ST_FIN, ST_SETWT,
    ST_EMPTY, ST_MEM, ST_MWAIT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [20:0]                 cp_r, cp_nxt;
  logic                        sel_r, sel_nxt;
  logic [usrl_pkg::SRCH_W-1:0] first_r, first_nxt, cnt_r, cnt_nxt;
  logic                        chk_r, chk_nxt;
  logic [7:0]                  prim_r, prim_nxt;
  logic                        hasx_r, hasx_nxt;
  logic [7:0]                  setn_r, setn_nxt;
  logic                        set_ok_r, set_ok_nxt;
  logic [5:0]                  size_r, size_nxt;
  logic [9:0]                  off_r, off_nxt;
  logic [4:0]                  k_r, k_nxt;
  usrl_pkg::out_word_t         out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic [usrl_pkg::SRCH_W-1:0]  n_scr, n_ext, n_sel, step, mid, srch_addr;
  logic [usrl_pkg::SETN_W-1:0]  n_set;
  logic [usrl_pkg::POOLN_W-1:0] n_pool;
  logic [10:0]                  pos;
  logic                         pool_ok, neutral, out_free, emit, hit;
  usrl_pkg::out_word_t          emit_word;
  usrl_pkg::range_t             scr_q, ext_q, rdata;
  usrl_pkg::set_rec_t           set_q, set_wd;
  logic [7:0]                   pool_q;
  logic [5:0]                   cnt_sat;
  logic                         load_go;

  // Counts clamped to the table depths.
  assign n_scr  = (cfg.script_range_count > usrl_pkg::SCRIPT_RANGES) ?
                  usrl_pkg::SRCH_W'(usrl_pkg::SCRIPT_RANGES) :
                  usrl_pkg::SRCH_W'(cfg.script_range_count);
  assign n_ext  = (cfg.ext_range_count > usrl_pkg::EXT_RANGES) ?
                  usrl_pkg::SRCH_W'(usrl_pkg::EXT_RANGES) :
                  usrl_pkg::SRCH_W'(cfg.ext_range_count);
  assign n_set  = (cfg.set_record_count > usrl_pkg::SET_RECORDS) ?
                  usrl_pkg::SETN_W'(usrl_pkg::SET_RECORDS) :
                  usrl_pkg::SETN_W'(cfg.set_record_count);
  assign n_pool = (cfg.pool_count > usrl_pkg::POOL_ENTRIES) ?
                  usrl_pkg::POOLN_W'(usrl_pkg::POOL_ENTRIES) :
                  usrl_pkg::POOLN_W'(cfg.pool_count);

  // Search address for the table being searched.
  assign n_sel     = sel_r ? n_ext : n_scr;
  assign step      = cnt_r >> 1;
  assign mid       = first_r + step;
  assign srch_addr = (cnt_r == '0) ? first_r : mid;
  assign rdata     = sel_r ? ext_q : scr_q;
  assign hit       = chk_r && (rdata.lo <= cp_r) && (cp_r <= rdata.hi);

  // Pool position of the current member.
  assign pos     = {1'b0, off_r} + 11'(k_r);
  assign pool_ok = (pos < n_pool);

  assign neutral = (prim_r == cfg.common_script_id) ||
                   (prim_r == cfg.inherited_script_id) ||
                   (prim_r == cfg.unknown_script_id);

  assign out_free  = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_word  = out_r;

  // Table writes happen as a load word leaves the queue.
  assign load_go = (state_r == ST_IDLE) && q_valid;
  assign cnt_sat = (q_item.word.member_count > usrl_pkg::MAX_SET_SIZE) ?
                   6'(usrl_pkg::MAX_SET_SIZE) : q_item.word.member_count;
  assign set_wd  = '{offset: q_item.word.pool_offset, count: cnt_sat};

  usrl_ram #(.WIDTH($bits(usrl_pkg::range_t)), .DEPTH(usrl_pkg::SCRIPT_RANGES)) u_scr (
    .clk   (clk),
    .we    (load_go && (q_item.op == usrl_pkg::OP_SCRIPT) &&
            (q_item.word.entry_index < usrl_pkg::SCRIPT_RANGES)),
    .waddr (usrl_pkg::SR_AW'(q_item.word.entry_index)),
    .wdata ({q_item.word.first_codepoint, q_item.word.last_codepoint,
             q_item.word.script_value}),
    .raddr (usrl_pkg::SR_AW'(srch_addr)),
    .rdata (scr_q)
  );

  usrl_ram #(.WIDTH($bits(usrl_pkg::range_t)), .DEPTH(usrl_pkg::EXT_RANGES)) u_ext (
    .clk   (clk),
    .we    (load_go && (q_item.op == usrl_pkg::OP_EXT) &&
            (q_item.word.entry_index < usrl_pkg::EXT_RANGES)),
    .waddr (usrl_pkg::ER_AW'(q_item.word.entry_index)),
    .wdata ({q_item.word.first_codepoint, q_item.word.last_codepoint,
             q_item.word.set_number}),
    .raddr (usrl_pkg::ER_AW'(srch_addr)),
    .rdata (ext_q)
  );

  usrl_ram #(.WIDTH($bits(usrl_pkg::set_rec_t)), .DEPTH(usrl_pkg::SET_RECORDS)) u_set (
    .clk   (clk),
    .we    (load_go && (q_item.op == usrl_pkg::OP_SET) &&
            (q_item.word.entry_index < usrl_pkg::SET_RECORDS)),
    .waddr (usrl_pkg::SET_AW'(q_item.word.entry_index)),
    .wdata (set_wd),
    .raddr (usrl_pkg::SET_AW'(setn_r)),
    .rdata (set_q)
  );

  usrl_ram #(.WIDTH(8), .DEPTH(usrl_pkg::POOL_ENTRIES)) u_pool (
    .clk   (clk),
    .we    (load_go && (q_item.op == usrl_pkg::OP_POOL) &&
            (q_item.word.entry_index < usrl_pkg::POOL_ENTRIES)),
    .waddr (usrl_pkg::POOL_AW'(q_item.word.entry_index)),
    .wdata (q_item.word.script_value),
    .raddr (usrl_pkg::POOL_AW'(pos)),
    .rdata (pool_q)
  );

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    cp_nxt     = cp_r;
    sel_nxt    = sel_r;
    first_nxt  = first_r;
    cnt_nxt    = cnt_r;
    chk_nxt    = chk_r;
    prim_nxt   = prim_r;
    hasx_nxt   = hasx_r;
    setn_nxt   = setn_r;
    set_ok_nxt = set_ok_r;
    size_nxt   = size_r;
    off_nxt    = off_r;
    k_nxt      = k_r;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_word  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cp_nxt   = q_item.word.codepoint;
          prim_nxt = cfg.unknown_script_id;
          hasx_nxt = 1'b0;
          sel_nxt  = 1'b0;
          first_nxt = '0;
          cnt_nxt  = n_scr;
          if (q_item.op != usrl_pkg::OP_LOOKUP) begin
            state_nxt = ST_ACK;
          end else if (q_item.oor) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_SRCH;
          end
        end
      end
      ST_ACK: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_word.last = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_SRCH: begin
        if (cnt_r == '0) begin
          chk_nxt   = (first_r < n_sel);
          state_nxt = ST_CHK;
        end else begin
          state_nxt = ST_SWAIT;
        end
      end
      ST_SWAIT: begin
        if (rdata.hi < cp_r) begin
          first_nxt = mid + 1'b1;
          cnt_nxt   = cnt_r - step - 1'b1;
        end else begin
          cnt_nxt = step;
        end
        state_nxt = ST_SRCH;
      end
      ST_CHK: begin
        if (!sel_r) begin
          if (hit) begin
            prim_nxt = rdata.tag;
          end
          sel_nxt   = 1'b1;
          first_nxt = '0;
          cnt_nxt   = n_ext;
          state_nxt = ST_SRCH;
        end else begin
          if (hit) begin
            hasx_nxt = 1'b1;
            setn_nxt = rdata.tag;
          end
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!hasx_r) begin
          if (out_free) begin
            emit                = 1'b1;
            emit_word           = '0;
            emit_word.primary_script  = prim_r;
            emit_word.primary_neutral = neutral;
            emit_word.member_script   = prim_r;
            emit_word.member_valid    = 1'b1;
            emit_word.last            = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          set_ok_nxt = (setn_r < n_set);
          state_nxt  = ST_SETWT;
        end
      end
      ST_SETWT: begin
        if (!set_ok_r) begin
          size_nxt = '0;
        end else if (set_q.count > usrl_pkg::RESULT_LIMIT) begin
          size_nxt = 6'(usrl_pkg::RESULT_LIMIT);
        end else begin
          size_nxt = set_q.count;
        end
        off_nxt   = set_q.offset;
        k_nxt     = '0;
        state_nxt = (size_nxt == '0) ? ST_EMPTY : ST_MEM;
      end
      ST_EMPTY: begin
        if (out_free) begin
          emit                      = 1'b1;
          emit_word.primary_script  = prim_r;
          emit_word.primary_neutral = neutral;
          emit_word.has_extensions  = 1'b1;
          emit_word.last            = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_MEM: begin
        state_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (out_free) begin
          emit                      = 1'b1;
          emit_word.primary_script  = prim_r;
          emit_word.primary_neutral = neutral;
          emit_word.has_extensions  = 1'b1;
          emit_word.member_script   = pool_ok ? pool_q : cfg.unknown_script_id;
          emit_word.member_position = k_r;
          emit_word.member_valid    = 1'b1;
          emit_word.last            = ((6'(k_r) + 6'd1) == size_r);
          if (emit_word.last) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_MEM;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_nxt       = emit ? emit_word : out_r;
    out_valid_nxt = emit ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cp_r     <= cp_nxt;
    sel_r    <= sel_nxt;
    first_r  <= first_nxt;
    cnt_r    <= cnt_nxt;
    chk_r    <= chk_nxt;
    prim_r   <= prim_nxt;
    hasx_r   <= hasx_nxt;
    setn_r   <= setn_nxt;
    set_ok_r <= set_ok_nxt;
    size_r   <= size_nxt;
    off_r    <= off_nxt;
    k_r      <= k_nxt;
    out_r    <= out_nxt;
  end

endmodule
`default_nettype wire

>>> design/unicode_script_range_lookup.sv
// A load or nop is dequeued, then acknowledged; a lookup is dequeued, then runs a binary
// search of the script ranges, then of the extension ranges; a probe is one registered
// range RAM read. An extension set reads its set record, then emits one word per member
// (one word if empty); an out-of-range code point skips both searches. Words are handled
// one at a time behind a 2-word input queue, and a waiting result word holds the back end.
// Synchronous active-low reset clears control state and configuration, not the table RAMs.
`default_nettype none
module unicode_script_range_lookup (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire usrl_pkg::in_word_t  in_word,
  output logic                     in_full,
  output logic                     out_empty,
  output usrl_pkg::out_word_t      out_word,
  input  wire logic                out_pop,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [11:0]         cfg_data
);

  usrl_pkg::cfg_t   cfg_r, cfg_nxt;
  logic             q_valid, q_pop;
  usrl_pkg::qitem_t q_item;

  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        usrl_pkg::CFG_SCRIPT_COUNT: cfg_nxt.script_range_count  = cfg_data;
        usrl_pkg::CFG_EXT_COUNT:    cfg_nxt.ext_range_count     = cfg_data[9:0];
        usrl_pkg::CFG_SET_COUNT:    cfg_nxt.set_record_count    = cfg_data[8:0];
        usrl_pkg::CFG_POOL_COUNT:   cfg_nxt.pool_count          = cfg_data[10:0];
        usrl_pkg::CFG_UNKNOWN_ID:   cfg_nxt.unknown_script_id   = cfg_data[7:0];
        usrl_pkg::CFG_COMMON_ID:    cfg_nxt.common_script_id    = cfg_data[7:0];
        usrl_pkg::CFG_INHERITED_ID: cfg_nxt.inherited_script_id = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{script_range_count: '0, ext_range_count: '0, set_record_count: '0,
                 pool_count: '0, unknown_script_id: 8'd255, common_script_id: 8'd0,
                 inherited_script_id: 8'd1};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  usrl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_word (in_word),
    .in_full (in_full),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  usrl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_word  (out_word),
    .out_pop   (out_pop)
  );

endmodule
`default_nettype wire

>>> design/usrl_checker.sv
// Port-level checker for the script lookup block, bound to the top level.
// Depends on usrl_pkg and the assertion macro header.
`default_nettype none
`include "unicode_script_range_lookup_macros.svh"
module usrl_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_empty,
  input wire usrl_pkg::out_word_t out_word,
  input wire logic                out_pop
);

  // No result word is shown right after reset.
  `USRL_ASSERT_RST(a_empty_after_reset, !rst_n, out_empty)

  // A waiting word that is not taken stays unchanged.
  `USRL_ASSERT_NEXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_word))

  // Acknowledgements and empty sets are always the final word.
  `USRL_ASSERT(a_invalid_last, !out_empty && !out_word.member_valid, out_word.last)

  // Without extensions the lone member sits at position zero and ends the lookup.
  `USRL_ASSERT(a_noext_single, !out_empty && !out_word.has_extensions,
               out_word.member_position == 5'd0 && out_word.last)

endmodule

bind unicode_script_range_lookup usrl_checker u_usrl_checker (.*);
`default_nettype wire
